// ===== sv/dotq_pkg.sv =====
// Shared types and codes for the deadline-ordered timer queue.
package dotq_pkg;

  typedef enum logic [1:0] {
    CMD_SCHEDULE = 2'd0,
    CMD_TICK     = 2'd1,
    CMD_QUERY    = 2'd2
  } cmd_t;

  typedef struct packed {
    logic [63:0] deadline;
    logic [31:0] handle;
  } entry_t;

  // result word, listed from the highest bit down
  typedef struct packed {
    logic [31:0] registration_number;
    logic        overflow;
    logic [4:0]  queued_count;
    logic        pending;
    logic [31:0] fired_handle;
    logic        fired;
  } result_t;

endpackage

// ===== sv/dotq_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module dotq_ram #(
  parameter int WIDTH = 96,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];  // read-first on address collision
  end

endmodule

// ===== sv/deadline_ordered_timer_queue.sv =====
// Top level of the deadline-ordered timer queue.
//
// Usage: one request enters on the s_axis channel (tuser = command, tdata =
// delay and callback handle) and exactly one status word leaves on m_axis.
// A schedule request clamps its delay to at least 1 ms, adds it to the
// current time and inserts the timer behind every entry whose deadline is
// earlier or equal. The insert walks the circular buffer from the tail
// toward the head, one entry per cycle through the shared deadline
// comparator, moving later entries up by one slot; a request that passes
// every entry writes the timer into the new head slot in a place step. A
// tick advances time by 1 ms and pops at most the head entry if it has
// expired; on an empty queue it skips the check. Query and overflow go
// straight to the result step.
// The block takes one request at a time; s_axis_tready is high only when
// it is idle. A finished result sits in the output register while the next
// request is accepted; if the receiver stalls with a result still held, the
// block waits before loading the next one.
// Reset (rst, synchronous) zeroes time, count and registration number. The
// timer RAM holds no reset value; only data from occupied slots is used.
module deadline_ordered_timer_queue #(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,   // [31:0] delay (signed), [63:32] callback_handle
  input  logic [1:0]  s_axis_tuser,   // [1:0] command
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [0] fired, [32:1] fired_handle, [33] pending, [38:34] queued_count,
  // [39] overflow, [71:40] registration_number
  output logic [71:0] m_axis_tdata
);

  localparam int PW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WALK,
    ST_PLACE,
    ST_TICK_CHK,
    ST_RESULT
  } state_t;

  function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
    return (p == PW'(QUEUE_DEPTH - 1)) ? '0 : p + PW'(1);
  endfunction

  function automatic logic [PW-1:0] ptr_dec(input logic [PW-1:0] p);
    return (p == '0) ? PW'(QUEUE_DEPTH - 1) : p - PW'(1);
  endfunction

  state_t           state;
  logic [63:0]      current_time;
  logic [PW-1:0]    head;
  logic [PW-1:0]    tail;
  logic [CW-1:0]    count;
  logic [31:0]      issue_number;
  logic [63:0]      new_deadline;
  logic [31:0]      new_handle;
  logic [PW-1:0]    walk_addr;
  logic [PW-1:0]    place_addr;
  logic [CW-1:0]    remaining;
  logic             res_fired;
  logic [31:0]      res_handle;
  logic             res_overflow;

  // RAM port
  logic             ram_we;
  logic [PW-1:0]    ram_waddr;
  dotq_pkg::entry_t ram_wdata;
  logic [PW-1:0]    ram_raddr;
  dotq_pkg::entry_t ram_rdata;

  // request decode
  logic             in_accept;
  logic signed [31:0] in_delay;
  logic [31:0]      delay_clamped;
  logic [63:0]      deadline_calc;
  logic             queue_full;

  // shared comparator: walk compares against the new deadline, tick against time
  logic [63:0]      cmp_ref;
  logic             head_le_ref;

  dotq_pkg::result_t result_word;
  logic [31:0]       count_wide;

  assign s_axis_tready = (state == ST_IDLE);
  assign in_accept     = s_axis_tvalid && s_axis_tready;
  assign in_delay      = s_axis_tdata[31:0];
  assign delay_clamped = (in_delay < 32'sd1) ? 32'd1 : s_axis_tdata[31:0];
  assign deadline_calc = current_time + {32'd0, delay_clamped};
  assign queue_full    = (count == CW'(QUEUE_DEPTH));

  assign cmp_ref     = (state == ST_WALK) ? new_deadline : current_time;
  assign head_le_ref = (ram_rdata.deadline <= cmp_ref);

  assign count_wide                       = 32'(count);
  assign result_word.registration_number  = issue_number;
  assign result_word.overflow             = res_overflow;
  assign result_word.queued_count         = count_wide[4:0];
  assign result_word.pending              = (count != '0);
  assign result_word.fired_handle         = res_handle;
  assign result_word.fired                = res_fired;

  dotq_ram #(
    .WIDTH ($bits(dotq_pkg::entry_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = place_addr;
    ram_wdata = '{deadline: new_deadline, handle: new_handle};
    ram_raddr = head;
    unique case (state)
      ST_IDLE: begin
        // schedule starts reading the last entry; tick reads the head
        if (in_accept && s_axis_tuser == dotq_pkg::CMD_SCHEDULE) begin
          ram_raddr = ptr_dec(tail);
        end
      end
      ST_WALK: begin
        ram_we    = 1'b1;
        ram_waddr = ptr_inc(walk_addr);
        if (!head_le_ref) begin
          ram_wdata = ram_rdata;  // later entry moves up one slot
        end
        ram_raddr = ptr_dec(walk_addr);
      end
      ST_PLACE: begin
        ram_we = 1'b1;
      end
      ST_TICK_CHK, ST_RESULT: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      current_time  <= '0;
      head          <= '0;
      tail          <= '0;
      count         <= '0;
      issue_number  <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      // the result state reloads or holds the output register itself
      if (m_axis_tvalid && m_axis_tready && state != ST_RESULT) begin
        m_axis_tvalid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (in_accept) begin
            res_fired    <= 1'b0;
            res_handle   <= '0;
            res_overflow <= 1'b0;
            new_deadline <= deadline_calc;
            new_handle   <= s_axis_tdata[63:32];
            place_addr   <= tail;
            walk_addr    <= ptr_dec(tail);
            remaining    <= count;
            unique case (s_axis_tuser)
              dotq_pkg::CMD_SCHEDULE: begin
                if (queue_full) begin
                  res_overflow <= 1'b1;
                  state        <= ST_RESULT;
                end else if (count == '0) begin
                  state <= ST_PLACE;
                end else begin
                  state <= ST_WALK;
                end
              end
              dotq_pkg::CMD_TICK: begin
                current_time <= current_time + 64'd1;
                state        <= (count == '0) ? ST_RESULT : ST_TICK_CHK;
              end
              default: begin
                state <= ST_RESULT;  // query and the unused code
              end
            endcase
          end
        end
        ST_WALK: begin
          if (head_le_ref) begin
            // new timer lands just above this entry
            tail         <= ptr_inc(tail);
            count        <= count + CW'(1);
            issue_number <= issue_number + 32'd1;
            state        <= ST_RESULT;
          end else if (remaining == CW'(1)) begin
            place_addr <= walk_addr;  // passed every entry: new head slot
            state      <= ST_PLACE;
          end else begin
            walk_addr <= ptr_dec(walk_addr);
            remaining <= remaining - CW'(1);
          end
        end
        ST_PLACE: begin
          tail         <= ptr_inc(tail);
          count        <= count + CW'(1);
          issue_number <= issue_number + 32'd1;
          state        <= ST_RESULT;
        end
        ST_TICK_CHK: begin
          if (head_le_ref) begin
            res_fired  <= 1'b1;
            res_handle <= ram_rdata.handle;
            head       <= ptr_inc(head);
            count      <= count - CW'(1);
          end
          state <= ST_RESULT;
        end
        ST_RESULT: begin
          if (!m_axis_tvalid || m_axis_tready) begin
            m_axis_tdata  <= result_word;
            m_axis_tvalid <= 1'b1;
            state         <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== tb/tb.sv =====
// Testbench for the deadline-ordered timer queue: directed vectors, random traffic, self-checking.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int          DEPTH      = 16;
  localparam int          RAND_ITEMS = 400;
  localparam int          IDLE_PCT   = 29;
  localparam logic [1:0]  CMD_UNUSED = 2'd3;  // no defined meaning, behaves like a query

  logic        clk;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [63:0] s_axis_tdata = '0;   // [31:0] delay (signed), [63:32] callback_handle
  logic [1:0]  s_axis_tuser = '0;   // [1:0] command
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  // [0] fired, [32:1] fired_handle, [33] pending, [38:34] queued_count,
  // [39] overflow, [71:40] registration_number
  logic [71:0] m_axis_tdata;

  deadline_ordered_timer_queue #(
    .QUEUE_DEPTH (DEPTH)
  ) i_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // directed vector: the expected status is typed in only when want_valid is set
  typedef struct {
    logic [1:0]        cmd;
    logic [31:0]       dly;
    logic [31:0]       hnd;
    bit                want_valid;
    dotq_pkg::result_t want;
  } vector_t;

  // shadow of the timer queue
  logic [63:0] now_ms;
  logic [63:0] due_ms [DEPTH];
  logic [31:0] due_tag [DEPTH];
  int unsigned held;
  logic [31:0] registrations;

  dotq_pkg::result_t status_due[$];
  vector_t           vectors[$];
  int unsigned       faults = 0;
  bit                calm = 1'b0;   // suppresses idling on both sides

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  // sink side: random backpressure except during the calm window
  always @(negedge clk) begin
    m_axis_tready <= calm || ($urandom_range(99) >= IDLE_PCT);
  end

  function automatic dotq_pkg::result_t make_status(logic f, logic [31:0] fh, logic p,
                                                    logic [4:0] n, logic ovf,
                                                    logic [31:0] reg_no);
    dotq_pkg::result_t r;
    r.fired               = f;
    r.fired_handle        = fh;
    r.pending             = p;
    r.queued_count        = n;
    r.overflow            = ovf;
    r.registration_number = reg_no;
    return r;
  endfunction

  // Applies one request to the shadow queue and returns the status it produces.
  function automatic dotq_pkg::result_t predict_status(logic [1:0] cmd, logic [31:0] dly,
                                                       logic [31:0] hnd);
    dotq_pkg::result_t r;
    logic [63:0]       deadline;
    logic [31:0]       clamped;
    int                pos;
    r = '0;
    case (cmd)
      dotq_pkg::CMD_SCHEDULE: begin
        if (held >= DEPTH) begin
          r.overflow = 1'b1;
        end else begin
          // anything below one millisecond, negatives included, becomes one
          clamped  = ($signed(dly) < 32'sd1) ? 32'd1 : dly;
          deadline = now_ms + {32'd0, clamped};
          pos = 0;
          // ties go behind existing entries
          while (pos < held && due_ms[pos] <= deadline) pos++;
          for (int i = held; i > pos; i--) begin
            due_ms[i]  = due_ms[i-1];
            due_tag[i] = due_tag[i-1];
          end
          due_ms[pos]  = deadline;
          due_tag[pos] = hnd;
          held++;
          registrations++;
        end
      end
      dotq_pkg::CMD_TICK: begin
        now_ms++;
        // at most one expired entry leaves per tick
        if (held > 0 && due_ms[0] <= now_ms) begin
          r.fired        = 1'b1;
          r.fired_handle = due_tag[0];
          for (int i = 1; i < held; i++) begin
            due_ms[i-1]  = due_ms[i];
            due_tag[i-1] = due_tag[i];
          end
          held--;
        end
      end
      default: ;  // query and the unused code only report status
    endcase
    r.pending             = (held > 0);
    r.queued_count        = held[4:0];
    r.registration_number = registrations;
    return r;
  endfunction

  // Drives one request, waits for the handshake and queues the expected status.
  task automatic put_request(input logic [1:0] cmd, input logic [31:0] dly,
                             input logic [31:0] hnd, input bit want_valid,
                             input dotq_pkg::result_t want);
    dotq_pkg::result_t predicted;
    @(negedge clk);
    while (!calm && $urandom_range(99) < IDLE_PCT) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= cmd;
    s_axis_tdata  <= {hnd, dly};
    do @(posedge clk); while (!s_axis_tready);
    predicted = predict_status(cmd, dly, hnd);
    status_due.push_back(want_valid ? want : predicted);
  endtask

  task automatic add_vector(input logic [1:0] cmd, input logic [31:0] dly,
                            input logic [31:0] hnd, input bit want_valid,
                            input dotq_pkg::result_t want);
    vector_t v;
    v.cmd        = cmd;
    v.dly        = dly;
    v.hnd        = hnd;
    v.want_valid = want_valid;
    v.want       = want;
    vectors.push_back(v);
  endtask

  function automatic logic [31:0] pick_delay();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 80) return $urandom_range(20);            // short, expires soon
    if (roll < 92) return $urandom | 32'h8000_0000;      // negative, clamps to one
    if (roll < 98) return $urandom_range(60, 21);
    return $urandom & 32'h7fff_ffff;                     // far future, stays queued
  endfunction

  task automatic report_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $realtime, name, want, got);
      faults++;
    end
  endtask

  // status checker
  always @(posedge clk) begin
    dotq_pkg::result_t got;
    dotq_pkg::result_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata;
      if (status_due.size() == 0) begin
        $display("%0t: unexpected status, expected none, actual %h", $realtime, got);
        faults++;
      end else begin
        want = status_due.pop_front();
        report_field("fired", want.fired, got.fired);
        report_field("fired_handle", want.fired_handle, got.fired_handle);
        report_field("pending", want.pending, got.pending);
        report_field("queued_count", want.queued_count, got.queued_count);
        report_field("overflow", want.overflow, got.overflow);
        report_field("registration_number", want.registration_number,
                     got.registration_number);
      end
    end
  end

  initial begin
    logic [1:0]  cmd;
    int unsigned sent;
    int unsigned kind;
    int unsigned run_len;
    int unsigned roll;

    now_ms        = '0;
    held          = 0;
    registrations = '0;

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed part. Status after reset, a tick on an empty queue and the
    // unused code are all zero; then the queue gets filled to the brim with
    // clamped, extreme and tied delays, one more schedule must overflow, and
    // a few ticks pop the earliest entries.
    add_vector(dotq_pkg::CMD_QUERY,    32'h0000_0000, 32'h0000_0000, 1'b1, '0);
    add_vector(dotq_pkg::CMD_TICK,     32'hffff_ffff, 32'hffff_ffff, 1'b1, '0);
    add_vector(CMD_UNUSED,             32'h0000_0007, 32'h0000_0009, 1'b1, '0);
    add_vector(dotq_pkg::CMD_SCHEDULE, 32'h0000_0000, 32'h0000_0000, 1'b1,
               make_status(1'b0, 32'd0, 1'b1, 5'd1, 1'b0, 32'd1));
    add_vector(dotq_pkg::CMD_SCHEDULE, 32'hffff_ffff, 32'hffff_ffff, 1'b0, '0);
    add_vector(dotq_pkg::CMD_SCHEDULE, 32'h8000_0000, 32'h0000_0001, 1'b0, '0);
    add_vector(dotq_pkg::CMD_SCHEDULE, 32'h7fff_ffff, 32'h8000_0000, 1'b0, '0);
    add_vector(dotq_pkg::CMD_SCHEDULE, 32'h0000_0001, 32'h1234_5678, 1'b0, '0);
    add_vector(dotq_pkg::CMD_SCHEDULE, 32'h0000_0005, 32'h0000_0005, 1'b0, '0);
    add_vector(dotq_pkg::CMD_SCHEDULE, 32'h0000_0005, 32'h0000_0006, 1'b0, '0);
    add_vector(dotq_pkg::CMD_SCHEDULE, 32'h0000_0003, 32'h0000_0003, 1'b0, '0);
    add_vector(dotq_pkg::CMD_SCHEDULE, 32'h0000_0002, 32'h0000_0002, 1'b0, '0);
    add_vector(dotq_pkg::CMD_SCHEDULE, 32'h0000_0009, 32'h0000_0009, 1'b0, '0);
    add_vector(dotq_pkg::CMD_SCHEDULE, 32'h0000_0004, 32'h0000_0004, 1'b0, '0);
    add_vector(dotq_pkg::CMD_SCHEDULE, 32'h0000_0008, 32'h0000_0008, 1'b0, '0);
    add_vector(dotq_pkg::CMD_SCHEDULE, 32'h0000_0006, 32'h5555_5555, 1'b0, '0);
    add_vector(dotq_pkg::CMD_SCHEDULE, 32'h0000_0007, 32'haaaa_aaaa, 1'b0, '0);
    add_vector(dotq_pkg::CMD_SCHEDULE, 32'h0000_000a, 32'h0000_000a, 1'b0, '0);
    add_vector(dotq_pkg::CMD_SCHEDULE, 32'h0000_0002, 32'h0000_0022, 1'b0, '0);
    add_vector(dotq_pkg::CMD_SCHEDULE, 32'h0000_0001, 32'hdead_0001, 1'b1,
               make_status(1'b0, 32'd0, 1'b1, 5'd16, 1'b1, 32'd16));
    add_vector(dotq_pkg::CMD_TICK,     32'h0000_0000, 32'h0000_0000, 1'b0, '0);
    add_vector(dotq_pkg::CMD_TICK,     32'h0000_0000, 32'h0000_0000, 1'b0, '0);
    add_vector(dotq_pkg::CMD_TICK,     32'h0000_0000, 32'h0000_0000, 1'b0, '0);
    add_vector(dotq_pkg::CMD_TICK,     32'h0000_0000, 32'h0000_0000, 1'b0, '0);
    add_vector(dotq_pkg::CMD_QUERY,    32'h0000_0000, 32'h0000_0000, 1'b0, '0);

    foreach (vectors[i])
      put_request(vectors[i].cmd, vectors[i].dly, vectors[i].hnd,
                  vectors[i].want_valid, vectors[i].want);

    // Random part in bursts: fill runs push the queue into overflow, drain
    // runs tick entries out, mixed runs interleave both.
    sent = 0;
    while (sent < RAND_ITEMS) begin
      kind    = $urandom_range(2);
      run_len = $urandom_range(30, 5);
      for (int j = 0; j < run_len; j++) begin
        calm = (sent >= 150 && sent < 230);
        roll = $urandom_range(99);
        case (kind)
          0:       cmd = (roll < 90) ? dotq_pkg::CMD_SCHEDULE : dotq_pkg::CMD_QUERY;
          1:       cmd = (roll < 85) ? dotq_pkg::CMD_TICK :
                         (roll < 95) ? dotq_pkg::CMD_SCHEDULE : dotq_pkg::CMD_QUERY;
          default: cmd = (roll < 45) ? dotq_pkg::CMD_SCHEDULE :
                         (roll < 90) ? dotq_pkg::CMD_TICK : dotq_pkg::CMD_QUERY;
        endcase
        if (cmd == dotq_pkg::CMD_QUERY && $urandom_range(1)) cmd = CMD_UNUSED;
        put_request(cmd, pick_delay(), $urandom, 1'b0, '0);
        sent++;
      end
    end
    calm = 1'b0;

    @(negedge clk);
    s_axis_tvalid <= 1'b0;

    while (status_due.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);

    if (faults == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ===== deadline_ordered_timer_queue.f =====
sv/dotq_pkg.sv
sv/dotq_ram.sv
sv/deadline_ordered_timer_queue.sv
tb/tb.sv
